// ===== sv/u8v_pkg.sv =====
package u8v_pkg;

    localparam logic [7:0] BYTE_HIGH     = 8'h80;
    localparam logic [7:0] LEAD_TWO      = 8'hC0;
    localparam logic [7:0] LEAD_THREE    = 8'hE0;
    localparam logic [7:0] LEAD_FOUR     = 8'hF0;
    localparam logic [7:0] LEAD_FIVE     = 8'hF8;
    localparam logic [7:0] LEAD_SIX_LO   = 8'hFC;
    localparam logic [7:0] LEAD_SIX_HI   = 8'hFD;
    localparam logic [1:0] CONT_TAG      = 2'b10;

    localparam int unsigned DATA_W = 8;

    typedef struct packed {
        logic [2:0] bytes_owed;
        logic       saw_high_byte;
        logic       error_seen;
    } state_t;

    typedef struct packed {
        logic all_ascii;
        logic malformed;
        logic is_utf8;
    } result_t;

    function automatic logic [2:0] owed_for_lead(input logic [7:0] b);
        logic [2:0] owed;
        if (b >= LEAD_SIX_LO && b <= LEAD_SIX_HI)
        begin
            owed = 3'd5;
        end
        else if (b >= LEAD_FIVE)
        begin
            owed = 3'd4;
        end
        else if (b >= LEAD_FOUR)
        begin
            owed = 3'd3;
        end
        else if (b >= LEAD_THREE)
        begin
            owed = 3'd2;
        end
        else
        begin
            owed = 3'd1;
        end
        return owed;
    endfunction

endpackage

// ===== sv/u8v_step.sv =====
module u8v_step (
    input  u8v_pkg::state_t  state_cur,
    input  logic [7:0]       data_byte,
    output u8v_pkg::state_t  state_upd,
    output u8v_pkg::result_t result
);
    import u8v_pkg::*;

    logic bad;

    always_comb
    begin
        state_upd = state_cur;
        if (data_byte[7])
        begin
            state_upd.saw_high_byte = 1'b1;
        end
        if (state_cur.bytes_owed == 3'd0)
        begin
            if (data_byte >= LEAD_TWO)
            begin
                state_upd.bytes_owed = owed_for_lead(data_byte);
            end
            else if (data_byte >= BYTE_HIGH)
            begin
                state_upd.error_seen = 1'b1;
            end
        end
        else
        begin
            if (data_byte[7:6] != CONT_TAG)
            begin
                state_upd.error_seen = 1'b1;
                state_upd.bytes_owed = 3'd0;
            end
            else
            begin
                state_upd.bytes_owed = state_cur.bytes_owed - 3'd1;
            end
        end
    end

    assign bad              = state_upd.error_seen || (state_upd.bytes_owed != 3'd0);
    assign result.is_utf8   = !bad && state_upd.saw_high_byte;
    assign result.malformed = bad;
    assign result.all_ascii = !state_upd.saw_high_byte;

endmodule

// ===== sv/utf8_stream_validator.sv =====
// Channel   Dir  Fields (low bit up)                          Accepted when
// s_*       in   tdata[7:0] data_byte, tlast last_byte        s_tvalid && s_tready
// m_*       out  tdata[0] is_utf8, [1] malformed,             m_tvalid && m_tready
//                [2] all_ascii, [7:3] zero
//
// One byte per cycle while no last byte waits; a last byte passes the input register,
// then its result is registered. The bytes_owed and flag update loops via state_reg.
// Reset clears the valid flags and the text state; the data registers are not reset.
// With m_tready low a finished result holds; bytes that are not last keep
// flowing, and a last byte waits in the input register until the result slot frees.
module utf8_stream_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] is_utf8, [1] malformed, [2] all_ascii
);
    import u8v_pkg::*;

    logic                in_valid_reg;
    logic [DATA_W-1:0]   in_byte_reg;
    logic                in_last_reg;
    state_t              state_reg;
    state_t              state_upd;
    state_t              state_next;
    result_t             step_result;
    logic                out_valid_reg;
    result_t             out_result_reg;
    logic                out_free;
    logic                advance;

    u8v_step u_step (
        .state_cur (state_reg),
        .data_byte (in_byte_reg),
        .state_upd (state_upd),
        .result    (step_result)
    );

    assign out_free   = !out_valid_reg || m_tready;
    assign advance    = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready   = !in_valid_reg || advance;
    assign state_next = in_last_reg ? state_t'('0) : state_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_result_reg.all_ascii, out_result_reg.malformed,
                       out_result_reg.is_utf8};

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> state_reg == state_t'('0))
        else $error("text state not cleared after last byte");

    a_exclusive_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_result_reg.is_utf8 && out_result_reg.malformed))
        else $error("result both valid UTF-8 and malformed");

    a_ascii_not_utf8: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.all_ascii |-> !out_result_reg.is_utf8)
        else $error("all-ASCII text flagged as UTF-8");

    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_last_reg && !out_free |=> in_valid_reg && in_last_reg)
        else $error("last byte dropped while result slot busy");

endmodule

// ===== dv/utf8_stream_checker.sv =====
`timescale 1ns / 1ps

module utf8_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    output int         fail_count,
    output int         outstanding
);
    import u8v_pkg::*;

    logic [2:0] cont_owed   = 3'd0;
    logic       high_seen   = 1'b0;
    logic       text_broken = 1'b0;
    result_t    verdicts_due[$];

    function automatic logic [2:0] lead_cont_count(input logic [7:0] b);
        if (b[7:1] == LEAD_SIX_LO[7:1])
            return 3'd5;
        if (b >= LEAD_FIVE)
            return 3'd4;
        if (b >= LEAD_FOUR)
            return 3'd3;
        if (b >= LEAD_THREE)
            return 3'd2;
        return 3'd1;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
        fail_count++;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        result_t verdict;
        logic    bad;
        if (b[7])
            high_seen = 1'b1;
        if (cont_owed == 3'd0)
        begin
            if (b >= LEAD_TWO)
                cont_owed = lead_cont_count(b);
            else if (b >= BYTE_HIGH)
                text_broken = 1'b1;
        end
        else if (b[7:6] != CONT_TAG)
        begin
            // missing continuation: byte is not reread as a lead
            text_broken = 1'b1;
            cont_owed   = 3'd0;
        end
        else
        begin
            cont_owed = cont_owed - 3'd1;
        end
        if (last)
        begin
            bad               = text_broken || (cont_owed != 3'd0);
            verdict.is_utf8   = !bad && high_seen;
            verdict.malformed = bad;
            verdict.all_ascii = !high_seen;
            verdicts_due.insert(verdicts_due.size(), verdict);
            cont_owed   = 3'd0;
            high_seen   = 1'b0;
            text_broken = 1'b0;
        end
    endtask

    task automatic check_verdict(input logic [7:0] word);
        result_t want;
        if (verdicts_due.size() == 0)
        begin
            report_mismatch("unexpected result", 0, word);
            return;
        end
        want = verdicts_due.pop_front();
        if (word[0] !== want.is_utf8)
            report_mismatch("is_utf8", want.is_utf8, word[0]);
        if (word[1] !== want.malformed)
            report_mismatch("malformed", want.malformed, word[1]);
        if (word[2] !== want.all_ascii)
            report_mismatch("all_ascii", want.all_ascii, word[2]);
        if (word[7:3] !== 5'd0)
            report_mismatch("tdata padding", 0, word[7:3]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_owed   = 3'd0;
            high_seen   = 1'b0;
            text_broken = 1'b0;
            fail_count  = 0;
            verdicts_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_verdict(m_tdata);
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tlast);
            outstanding <= verdicts_due.size();
        end
    end

endmodule

// ===== dv/tb_utf8_stream_validator.sv =====
`timescale 1ns / 1ps

module tb_utf8_stream_validator;
    import u8v_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TEXT_BYTES  = 750;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;

    int         fail_count;
    int         outstanding;
    int         cycle_count = 0;
    int         sink_cycle  = 0;
    bit         steady_send = 1'b0;
    logic [7:0] text_bytes[$];

    always #5 clk = ~clk;

    utf8_stream_validator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    utf8_stream_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sink: random stalls, one long hold-off to back up the input, then a steady stretch
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            sink_cycle++;
            if (sink_cycle >= 300 && sink_cycle < 500)
                m_tready <= 1'b0;
            else if (sink_cycle >= 700 && sink_cycle < 1000)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 20);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        if (!steady_send)
        begin
            while ($urandom_range(99) < 20)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
            push_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    function automatic void add_piece();
        int         len;
        int         k;
        logic [7:0] lead;
        if ($urandom_range(99) < 45)
        begin
            text_bytes = {text_bytes, 8'($urandom_range(0, 127))};
            return;
        end
        len = $urandom_range(2, 6);
        case (len)
            2: lead = LEAD_TWO | 8'($urandom_range(0, 31));
            3: lead = LEAD_THREE | 8'($urandom_range(0, 15));
            4: lead = LEAD_FOUR | 8'($urandom_range(0, 7));
            5:
            begin
                k    = $urandom_range(0, 5);
                lead = (k < 4) ? LEAD_FIVE + 8'(k) : 8'hFA + 8'(k);
            end
            default: lead = LEAD_SIX_LO | 8'($urandom_range(0, 1));
        endcase
        text_bytes = {text_bytes, lead};
        for (int i = 1; i < len; i++)
            text_bytes = {text_bytes, {CONT_TAG, 6'($urandom_range(0, 63))}};
    endfunction

    function automatic void make_text();
        int mode;
        int idx;
        text_bytes.delete();
        mode = $urandom_range(99);
        if (mode >= 90)
        begin
            repeat ($urandom_range(1, 8))
                text_bytes = {text_bytes, 8'($urandom_range(0, 255))};
            return;
        end
        repeat ($urandom_range(1, 5))
            add_piece();
        if (mode >= 70)
        begin
            idx = $urandom_range(0, text_bytes.size() - 1);
            case ($urandom_range(0, 2))
                0: text_bytes[idx] = 8'($urandom_range(0, 255));
                1:
                begin
                    if (text_bytes.size() > 1)
                        void'(text_bytes.pop_back());
                end
                default: text_bytes.insert(idx, {CONT_TAG, 6'($urandom_range(0, 63))});
            endcase
        end
    endfunction

    initial
    begin
        int sent;
        int text_no;
        sent    = 0;
        text_no = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        text_bytes = '{8'h00};
        send_text();
        text_bytes = '{8'h7F};
        send_text();
        text_bytes = '{8'hFF};
        send_text();
        text_bytes = '{8'hC3, 8'hA9};
        send_text();
        text_bytes = '{8'h80};
        send_text();
        text_bytes = '{8'hE2, 8'h82, 8'hAC};
        send_text();
        text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};
        send_text();
        text_bytes = '{8'hF8, 8'h88, 8'h80, 8'h80, 8'hBF};
        send_text();
        text_bytes = '{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
        send_text();
        text_bytes = '{8'hC3, 8'h41};
        send_text();

        while (sent < TEXT_BYTES)
        begin
            steady_send = (text_no >= 40 && text_no < 70);
            make_text();
            send_text();
            sent += text_bytes.size();
            text_no++;
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/u8v_pkg.sv
sv/u8v_step.sv
sv/utf8_stream_validator.sv
dv/utf8_stream_checker.sv
dv/tb_utf8_stream_validator.sv
